// ----- src/two_level_priority_queue_top_assert.svh -----
// Assertion macros used by the priority queue RTL
`ifndef TWO_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define TWO_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TPLQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tplq assertion failed");

// Next-cycle implication, disabled during reset
`define TPLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tplq assertion failed");

`endif

// ----- src/tplq_pkg.sv -----
// Types and constants of the two-level priority queue
package tplq_pkg;

  localparam int LEN_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int LEN_MIN_RESET = 8;
  localparam int LEN_MAX_RESET = 64;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [LEN_W-1:0]    len_t;

  localparam cmd_t CMD_PUSH  = 2'd0;
  localparam cmd_t CMD_POP   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;
  localparam cmd_t CMD_NOP   = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SHORT = 2'd1;
  localparam status_t ST_LONG  = 2'd2;

  localparam logic REG_MIN_LENGTH = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

endpackage

// ----- src/tplq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module tplq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/two_level_priority_queue_top.sv -----
// Top level of the two-level strict priority queue
//
// Usage: one command transaction enters on cmd/priority_req/message_tag/
// message_length (in_valid/in_ready) and exactly one result transaction leaves
// on the out_* ports (out_valid/out_ready). Commands: push, pop, clear, no-op.
// High-priority pushes queue behind earlier high entries but ahead of every
// normal entry; a pop takes the oldest high entry, else the oldest normal one.
// Entries live in one RAM split into two ring buffers, one per class.
// Push, clear, no-op and a pop of an empty queue give their result in the
// cycle after acceptance; a pop that returns an entry first passes a fetch
// state (pending), as the head is read from the RAM (registered read) before
// the result is loaded. Throughput: one command per cycle for non-popping
// commands while the result is drained; no command is taken during a fetch.
// Configuration (cfg_write/cfg_index/cfg_data) sets min_length and max_length;
// write it only while no command is in flight.
// Reset empties the queue and restores min_length 8, max_length 64; no RAM
// clearing pass is needed since only written entries are ever read.
// A stalled receiver (out_ready low) holds the result register and drops
// in_ready, so no transaction is lost.
module two_level_priority_queue_top #(
  parameter int CAPACITY = 4,
  parameter int TAG_BITS = 8,
  parameter int CNT_W    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  tplq_pkg::len_t        cfg_data,
  // command channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tplq_pkg::cmd_t        cmd,
  input  logic                  priority_req,
  input  logic [TAG_BITS-1:0]   message_tag,
  input  tplq_pkg::len_t        message_length,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  push_accepted,
  output logic                  pop_valid,
  output logic [TAG_BITS-1:0]   out_tag,
  output logic                  out_priority,
  output tplq_pkg::status_t     out_length_status,
  output logic [CNT_W-1:0]      occupancy,
  output logic                  queue_full,
  output logic                  queue_empty
);

  import tplq_pkg::*;

  localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ADDR_W = PTR_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int WORD_W = TAG_BITS + STATUS_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);

  // configuration registers
  len_t min_length;
  len_t max_length;

  // queue state
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] high_count, high_count_next;
  logic [PTR_W-1:0] hi_wr, hi_rd, lo_wr, lo_rd;
  logic             pending;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic    accept, is_push, is_pop, is_clear, push_ok, pop_ok, pop_high;
  status_t len_status;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ready = !pending && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_push  = (cmd == CMD_PUSH);
  assign is_pop   = (cmd == CMD_POP);
  assign is_clear = (cmd == CMD_CLEAR);
  assign push_ok  = is_push && (entry_count < CNT_CAP);
  assign pop_ok   = is_pop && (entry_count != '0);
  assign pop_high = (high_count != '0);

  // too short wins when both limits are violated
  always_comb begin
    if (message_length < min_length) begin
      len_status = ST_SHORT;
    end else if (message_length > max_length) begin
      len_status = ST_LONG;
    end else begin
      len_status = ST_OK;
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    high_count_next  = high_count;
    if (push_ok) begin
      entry_count_next = entry_count + CNT_W'(1);
      high_count_next  = high_count + CNT_W'(priority_req);
    end else if (pop_ok) begin
      entry_count_next = entry_count - CNT_W'(1);
      high_count_next  = high_count - CNT_W'(pop_high);
    end else if (is_clear) begin
      entry_count_next = '0;
      high_count_next  = '0;
    end
  end

  // write the pushed entry at the tail of its class ring
  assign ram_we    = accept && push_ok;
  assign ram_waddr = {priority_req, priority_req ? hi_wr : lo_wr};
  assign ram_wdata = {len_status, message_tag};
  // read the head continuously; data is used the cycle after a pop
  assign ram_raddr = {pop_high, pop_high ? hi_rd : lo_rd};

  tplq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= LEN_W'(LEN_MIN_RESET);
      max_length <= LEN_W'(LEN_MAX_RESET);
    end else if (cfg_write) begin
      if (cfg_index == REG_MIN_LENGTH) begin
        min_length <= cfg_data;
      end else begin
        max_length <= cfg_data;
      end
    end
  end

  // control state: counts, ring pointers, result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      high_count  <= '0;
      hi_wr       <= '0;
      hi_rd       <= '0;
      lo_wr       <= '0;
      lo_rd       <= '0;
      pending     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= entry_count_next;
        high_count  <= high_count_next;
        if (push_ok) begin
          if (priority_req) begin
            hi_wr <= ptr_inc(hi_wr);
          end else begin
            lo_wr <= ptr_inc(lo_wr);
          end
        end else if (pop_ok) begin
          if (pop_high) begin
            hi_rd <= ptr_inc(hi_rd);
          end else begin
            lo_rd <= ptr_inc(lo_rd);
          end
        end else if (is_clear) begin
          // drop everything: read pointers catch up with write pointers
          hi_rd <= hi_wr;
          lo_rd <= lo_wr;
        end
        pending   <= pop_ok;
        out_valid <= !pop_ok;
      end else if (pending) begin
        pending   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      push_accepted     <= push_ok;
      pop_valid         <= pop_ok;
      out_priority      <= pop_ok && pop_high;
      out_tag           <= '0;
      out_length_status <= ST_OK;
      occupancy         <= entry_count_next;
      queue_full        <= (entry_count_next == CNT_CAP);
      queue_empty       <= (entry_count_next == '0);
    end else if (pending) begin
      out_tag           <= ram_rdata[TAG_BITS-1:0];
      out_length_status <= ram_rdata[WORD_W-1:TAG_BITS];
    end
  end

  `include "two_level_priority_queue_top_assert.svh"

  `TPLQ_ASSERT_NOW(a_high_within_count, clk, rst, 1'b1, high_count <= entry_count)
  `TPLQ_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, entry_count <= CNT_CAP)
  `TPLQ_ASSERT_NOW(a_no_accept_while_fetch, clk, rst, pending, !in_ready && !out_valid)
  `TPLQ_ASSERT_NEXT(a_fetch_delivers, clk, rst, pending, out_valid && pop_valid)

endmodule

// ----- test/two_level_priority_queue_checker.sv -----
// Scoreboard for the two-level priority queue: predicts every result and compares it
module two_level_priority_queue_checker #(
  parameter int CAPACITY = 4,
  parameter int TAG_BITS = 8,
  parameter int CNT_W    = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  tplq_pkg::len_t       cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  tplq_pkg::cmd_t       cmd,
  input  logic                 priority_req,
  input  logic [TAG_BITS-1:0]  message_tag,
  input  tplq_pkg::len_t       message_length,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 push_accepted,
  input  logic                 pop_valid,
  input  logic [TAG_BITS-1:0]  out_tag,
  input  logic                 out_priority,
  input  tplq_pkg::status_t    out_length_status,
  input  logic [CNT_W-1:0]     occupancy,
  input  logic                 queue_full,
  input  logic                 queue_empty,
  output int                   failures,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tplq_pkg::*;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                high;
    status_t             status;
  } slot_t;

  typedef struct packed {
    logic                pushed;
    logic                popped;
    logic [TAG_BITS-1:0] tag;
    logic                high;
    status_t             status;
    logic [CNT_W-1:0]    count;
    logic                full;
    logic                empty;
  } outcome_t;

  slot_t    slots [CAPACITY];
  int       fill;
  int       high_fill;
  len_t     shortest;
  len_t     longest;
  outcome_t awaited_outcomes [$];

  function automatic status_t grade_length(len_t len);
    if (len < shortest) return ST_SHORT;
    if (len > longest) return ST_LONG;
    return ST_OK;
  endfunction

  // Apply one command to the shadow queue and return what the block should report
  function automatic outcome_t apply_command(cmd_t op, logic is_high,
                                             logic [TAG_BITS-1:0] msg_tag, len_t len);
    outcome_t res;
    int       pos;
    res = '0;
    case (op)
      CMD_PUSH: begin
        if (fill < CAPACITY) begin
          pos = is_high ? high_fill : fill;
          for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = '{tag: msg_tag, high: is_high, status: grade_length(len)};
          fill++;
          if (is_high) high_fill++;
          res.pushed = 1'b1;
        end
      end
      CMD_POP: begin
        if (fill > 0) begin
          res.popped = 1'b1;
          res.tag    = slots[0].tag;
          res.high   = slots[0].high;
          res.status = slots[0].status;
          if (high_fill > 0) high_fill--;
          for (int i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
          fill--;
        end
      end
      CMD_CLEAR: begin
        fill = 0;
        high_fill = 0;
      end
      default: ;
    endcase
    res.count = CNT_W'(fill);
    res.full  = (fill == CAPACITY);
    res.empty = (fill == 0);
    return res;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      failures++;
      if (failures <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, seen);
    end
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      fill      = 0;
      high_fill = 0;
      shortest  = len_t'(LEN_MIN_RESET);
      longest   = len_t'(LEN_MAX_RESET);
      awaited_outcomes.delete();
      failures  = 0;
      pending  <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MIN_LENGTH) shortest = cfg_data;
        else longest = cfg_data;
      end
      // a result leaving now always belongs to an earlier command
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          failures++;
          if (failures <= 10) $display("%0t: result with nothing outstanding", $realtime);
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("push_accepted", want.pushed, push_accepted);
          check_field("pop_valid", want.popped, pop_valid);
          check_field("out_tag", want.tag, out_tag);
          check_field("out_priority", want.high, out_priority);
          check_field("out_length_status", want.status, out_length_status);
          check_field("occupancy", want.count, occupancy);
          check_field("queue_full", want.full, queue_full);
          check_field("queue_empty", want.empty, queue_empty);
        end
      end
      if (in_valid && in_ready)
        awaited_outcomes.push_back(apply_command(cmd, priority_req, message_tag,
                                                 message_length));
      pending <= awaited_outcomes.size();
    end
  end

endmodule

// ----- test/tb_two_level_priority_queue_top.sv -----
// Testbench top for the two-level priority queue: stimulus, receiver pacing and verdict
module tb_two_level_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tplq_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  len_t       cfg_data;
  logic       in_valid;
  logic       in_ready;
  cmd_t       cmd;
  logic       priority_req;
  logic [7:0] message_tag;
  len_t       message_length;
  logic       out_valid;
  logic       out_ready;
  logic       push_accepted;
  logic       pop_valid;
  logic [7:0] out_tag;
  logic       out_priority;
  status_t    out_length_status;
  logic [2:0] occupancy;
  logic       queue_full;
  logic       queue_empty;
  int         failures;
  int         pending;

  // Pacing controls shared between the sender and the receiver
  bit   calm;       // no idling on either side
  bit   long_hold;  // ask the receiver for one long stall
  len_t lo_len;     // length limits currently programmed, used to aim lengths at edges
  len_t hi_len;

  two_level_priority_queue_top dut (.*);

  two_level_priority_queue_checker queue_check (.*);

  always #10 clk = ~clk;

  // Safety net: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("tb_two_level_priority_queue_top: done, errors");
    $finish;
  end

  // Receiver: mostly ready, with random stall bursts and one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering commands meanwhile.
  initial begin : drain
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 60;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one command and hold it until the transaction completes.
  // Entered and left in the time step of a rising edge.
  task automatic issue(cmd_t op, logic is_high, logic [7:0] tag, len_t len);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= op;
    priority_req   <= is_high;
    message_tag    <= tag;
    message_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  // Aim lengths at the programmed limits and just past them, else anywhere
  function automatic len_t pick_length();
    case ($urandom_range(0, 7))
      0: return lo_len;
      1: return hi_len;
      2: return lo_len - 8'd1;
      3: return hi_len + 8'd1;
      default: return len_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic issue_random(int push_pct);
    int   roll;
    cmd_t op;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) op = CMD_PUSH;
    else if (roll < 90) op = CMD_POP;
    else if (roll < 95) op = CMD_NOP;
    else op = CMD_CLEAR;
    issue(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_length());
  endtask

  // Alternate fill-heavy and drain-heavy stretches so the queue swings between
  // empty and full with mixed classes inside
  task automatic run_random(int count);
    for (int i = 0; i < count; i++) issue_random(((i / 16) % 2) ? 25 : 70);
  endtask

  // Stop offering and wait until every outstanding result has been taken,
  // then let the pop latency settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program both limits on consecutive edges; only call while idle
  task automatic write_limits(len_t lo_v, len_t hi_v);
    cfg_write <= 1'b1;
    cfg_index <= REG_MIN_LENGTH;
    cfg_data  <= lo_v;
    @(posedge clk);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data  <= hi_v;
    @(posedge clk);
    cfg_write <= 1'b0;
    lo_len = lo_v;
    hi_len = hi_v;
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= REG_MIN_LENGTH;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    cmd            <= CMD_NOP;
    priority_req   <= 1'b0;
    message_tag    <= '0;
    message_length <= '0;
    calm      = 1'b0;
    long_hold = 1'b0;
    lo_len    = len_t'(LEN_MIN_RESET);
    hi_len    = len_t'(LEN_MAX_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset limits (8..64)
    issue(CMD_POP, 1'b1, 8'hFF, 8'd255);   // pop of an empty queue
    issue(CMD_NOP, 1'b0, 8'h00, 8'd0);     // no-op on empty
    issue(CMD_PUSH, 1'b0, 8'h00, 8'd0);    // normal, too short
    issue(CMD_PUSH, 1'b0, 8'hFF, 8'd255);  // normal, too long
    issue(CMD_PUSH, 1'b1, 8'hA5, 8'd8);    // high, exactly the minimum
    issue(CMD_PUSH, 1'b1, 8'h5A, 8'd64);   // high, exactly the maximum: now full
    issue(CMD_PUSH, 1'b0, 8'h11, 8'd20);   // push to a full queue, rejected
    issue(CMD_PUSH, 1'b1, 8'h22, 8'd20);   // high push to a full queue, rejected
    issue(CMD_NOP, 1'b1, 8'hFF, 8'd255);   // no-op while full
    repeat (4) issue(CMD_POP, 1'b0, 8'h00, 8'd0);
    issue(CMD_POP, 1'b0, 8'h00, 8'd0);     // empty again
    issue(CMD_PUSH, 1'b0, 8'h31, 8'd7);    // just below the minimum
    issue(CMD_PUSH, 1'b0, 8'h32, 8'd65);   // just above the maximum
    issue(CMD_PUSH, 1'b1, 8'h33, 8'd9);    // high overtakes both normals
    issue(CMD_POP, 1'b0, 8'h00, 8'd0);
    issue(CMD_CLEAR, 1'b1, 8'hFF, 8'd255); // clear with entries held
    issue(CMD_POP, 1'b0, 8'h00, 8'd0);     // nothing left after clear
    issue(CMD_CLEAR, 1'b0, 8'h00, 8'd0);   // clear of an empty queue
    issue(CMD_PUSH, 1'b1, 8'h0F, 8'd63);
    issue(CMD_POP, 1'b0, 8'h00, 8'd0);

    run_random(80);
    // Stall the receiver for a long stretch while commands keep coming,
    // so the result register fills and the input backs up
    long_hold = 1'b1;
    run_random(70);
    wait_drained();

    write_limits(8'd0, 8'd255);            // every length accepted
    run_random(60);
    wait_drained();                        // sender pauses until all results are in
    run_random(60);
    wait_drained();

    write_limits(8'd255, 8'd0);            // minimum above maximum: short wins
    run_random(100);
    wait_drained();

    write_limits(8'd0, 8'd0);
    run_random(100);
    wait_drained();

    write_limits(8'd255, 8'd255);
    run_random(90);
    wait_drained();

    write_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(60);
    // Final stretch at full rate on both sides
    calm = 1'b1;
    run_random(60);
    wait_drained();

    if (failures == 0 && pending == 0) begin
      $display("tb_two_level_priority_queue_top: done, clean");
    end else begin
      $display("tb_two_level_priority_queue_top: done, errors");
    end
    $finish;
  end

endmodule
